// File: hw/rtl/bmlc_pkg.sv
// Package: shared types and constants for the button mode LED controller.
`timescale 1ns / 1ps
`default_nettype none

package bmlc_pkg;

    localparam int unsigned COUNT_W = 16;
    localparam int unsigned PCT_W   = 7;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Register reset values
    localparam logic [COUNT_W-1:0] LONG_TICKS_RST = 16'd1000;
    localparam logic [PCT_W-1:0]   LOW_THR_RST    = 7'd33;
    localparam logic [PCT_W-1:0]   HIGH_THR_RST   = 7'd66;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR   = 2'd2;

    // Mode codes
    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_NORMAL = 2'd1;
    localparam logic [1:0] MODE_BLUE   = 2'd2;

    // LED color codes
    localparam logic [2:0] LED_OFF    = 3'd0;
    localparam logic [2:0] LED_RED    = 3'd1;
    localparam logic [2:0] LED_YELLOW = 3'd2;
    localparam logic [2:0] LED_GREEN  = 3'd3;
    localparam logic [2:0] LED_BLUE   = 3'd4;

    // Press event codes
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_SHORT = 2'd1;
    localparam logic [1:0] EV_LONG  = 2'd2;

    typedef struct packed {
        logic             button_level;
        logic [PCT_W-1:0] brightness_percent;
    } in_word_t;

    typedef struct packed {
        logic [1:0] current_mode;
        logic [2:0] led_color;
        logic [1:0] press_event;
        logic       measure_request;
    } out_word_t;

    typedef struct packed {
        logic [COUNT_W-1:0] long_press_ticks;
        logic [PCT_W-1:0]   low_threshold;
        logic [PCT_W-1:0]   high_threshold;
    } cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/bmlc_cfg.sv
// Configuration register file: hold press timing and brightness thresholds.
`timescale 1ns / 1ps
`default_nettype none

module bmlc_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [bmlc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bmlc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output bmlc_pkg::cfg_t                           cfg
);

    bmlc_pkg::cfg_t cfg_reg;
    bmlc_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                bmlc_pkg::REG_LONG_TICKS:
                    cfg_next.long_press_ticks = cfg_data[bmlc_pkg::COUNT_W-1:0];
                bmlc_pkg::REG_LOW_THR:
                    cfg_next.low_threshold = cfg_data[bmlc_pkg::PCT_W-1:0];
                bmlc_pkg::REG_HIGH_THR:
                    cfg_next.high_threshold = cfg_data[bmlc_pkg::PCT_W-1:0];
                default:
                    cfg_next = cfg_reg;  // unmapped index: drop the write
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ticks <= bmlc_pkg::LONG_TICKS_RST;
            cfg_reg.low_threshold    <= bmlc_pkg::LOW_THR_RST;
            cfg_reg.high_threshold   <= bmlc_pkg::HIGH_THR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/bmlc_core.sv
// Press detector and mode update: hold counter, mode register, LED color.
`timescale 1ns / 1ps
`default_nettype none

module bmlc_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire bmlc_pkg::in_word_t   in_word,
    input  wire bmlc_pkg::cfg_t       cfg,
    output bmlc_pkg::out_word_t       result
);

    logic [1:0]                   mode_reg, mode_next;
    logic                         held_reg, held_next;
    logic                         done_reg, done_next;
    logic [bmlc_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [1:0]                   event_c;
    logic                         measure_c;
    logic [2:0]                   color_c;

    always_comb
    begin
        mode_next  = mode_reg;
        held_next  = held_reg;
        done_next  = done_reg;
        count_next = count_reg;
        event_c    = bmlc_pkg::EV_NONE;
        measure_c  = 1'b0;

        if (in_word.button_level)
        begin
            if (!held_reg)
            begin
                held_next  = 1'b1;
                done_next  = 1'b0;
                count_next = {{(bmlc_pkg::COUNT_W-1){1'b0}}, 1'b1};
            end
            else if (count_reg != bmlc_pkg::COUNT_MAX)
            begin
                count_next = count_reg + 1'b1;
            end

            if (!done_next && (count_next >= cfg.long_press_ticks))
            begin
                done_next = 1'b1;
                event_c   = bmlc_pkg::EV_LONG;
                if (mode_reg == bmlc_pkg::MODE_NORMAL || mode_reg == bmlc_pkg::MODE_BLUE)
                begin
                    mode_next = bmlc_pkg::MODE_OFF;
                end
                else
                begin
                    mode_next = bmlc_pkg::MODE_NORMAL;
                    measure_c = 1'b1;
                end
            end
        end
        else if (held_reg)
        begin
            if (!done_reg)
            begin
                event_c = bmlc_pkg::EV_SHORT;
                if (mode_reg == bmlc_pkg::MODE_NORMAL)
                begin
                    mode_next = bmlc_pkg::MODE_BLUE;
                end
                else if (mode_reg == bmlc_pkg::MODE_BLUE)
                begin
                    mode_next = bmlc_pkg::MODE_NORMAL;
                    measure_c = 1'b1;
                end
            end
            held_next  = 1'b0;
            done_next  = 1'b0;
            count_next = '0;
        end
    end

    always_comb
    begin
        case (mode_next)
            bmlc_pkg::MODE_BLUE:
                color_c = bmlc_pkg::LED_BLUE;
            bmlc_pkg::MODE_NORMAL:
            begin
                if (in_word.brightness_percent < cfg.low_threshold)
                    color_c = bmlc_pkg::LED_RED;
                else if (in_word.brightness_percent < cfg.high_threshold)
                    color_c = bmlc_pkg::LED_YELLOW;
                else
                    color_c = bmlc_pkg::LED_GREEN;
            end
            default:
                color_c = bmlc_pkg::LED_OFF;
        endcase
    end

    assign result.current_mode    = mode_next;
    assign result.led_color       = color_c;
    assign result.press_event     = event_c;
    assign result.measure_request = measure_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= bmlc_pkg::MODE_NORMAL;
            held_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            held_reg  <= held_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/button_mode_led_controller_top.sv
// Top level: input word register, press/mode core, result word register, config port.
`timescale 1ns / 1ps
`default_nettype none

// An accepted word is staged in the input register, its result in the result register,
// then shown on out_valid. One word per cycle unless out_stall holds: the two-stage (input
// and result registers) pipeline advances whenever the result register is empty or being taken.
// Reset (rst_n, async, active low): mode normal, hold counter and flags clear,
// registers at 1000 / 33 / 66 ticks and percent, both pipeline stages empty.
// cfg_ready is always high; a write to an index beyond 2 is dropped.

module button_mode_led_controller_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire bmlc_pkg::in_word_t               in_word,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output bmlc_pkg::out_word_t                   out_word,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [bmlc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bmlc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    bmlc_pkg::cfg_t      cfg;
    bmlc_pkg::in_word_t  s1_word_reg;
    logic                s1_valid_reg, s1_valid_next;
    bmlc_pkg::out_word_t result;
    bmlc_pkg::out_word_t out_word_reg;
    logic                out_valid_reg, out_valid_next;
    logic                advance;
    logic                step;
    logic                in_take;

    // The result register can load when it is empty or its word leaves this cycle.
    assign advance  = !out_valid_reg || !out_stall;
    // Process the staged input word when the result register has room for it.
    assign step     = s1_valid_reg && advance;
    // Hold the input side only when the staged word cannot move on.
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    assign s1_valid_next  = in_take || (s1_valid_reg && !step);
    assign out_valid_next = step || (out_valid_reg && out_stall);

    bmlc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Core state commits only on step, so each word sees the state left by the one before.
    bmlc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .in_word (s1_word_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: no reset, load only on their handshake.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_word_reg <= in_word;
        end
        if (step)
        begin
            out_word_reg <= result;
        end
    end

endmodule

`default_nettype wire
